FILE: rtl/lcdns_pkg.sv
// Shared types, constants and the init sequence table for the LCD nibble sequencer.
package lcdns_pkg;

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_CMD    = 3'd1,
    MODE_DATA   = 3'd2,
    MODE_CURSOR = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CFG_STROBE  = 3'd0,
    CFG_SETTLE  = 3'd1,
    CFG_LONG    = 3'd2,
    CFG_POWERUP = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PB_NONE    = 2'd0,
    PB_POWERUP = 2'd1,
    PB_WAKE2   = 2'd2,
    PB_WAKE3   = 2'd3
  } pause_sel_e;

  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam int unsigned InitSteps = 12;
  localparam int unsigned StepW     = $clog2(InitSteps);

  localparam logic [7:0]  CmdClear   = 8'h01;
  localparam logic [7:0]  CmdHome    = 8'h02;
  localparam logic [7:0]  CmdDdram   = 8'h80;
  localparam logic [7:0]  Row1Offset = 8'h40;
  localparam logic [7:0]  MaxColumn  = 8'd15;
  localparam logic [19:0] Wake2Us    = 20'd5000;
  localparam logic [19:0] Wake3Us    = 20'd150;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] byte_value;
    logic [7:0] row;
    logic [7:0] column;
  } req_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [19:0] pause_before_us;
    logic [15:0] pause_after_us;
    logic        last;
  } res_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic       is_init;
    logic       reg_select;
    logic       long_wait;
    logic [7:0] byte_value;
  } job_t;

  typedef struct packed {
    logic [3:0] nibble;
    pause_sel_e pause_sel;
    logic       long_wait;
  } init_xfer_t;

  function automatic init_xfer_t init_xfer(logic [StepW-1:0] step);
    init_xfer_t x;
    x = '{nibble: 4'h0, pause_sel: PB_NONE, long_wait: 1'b0};
    case (step)
      4'd0:  x = '{nibble: 4'h3, pause_sel: PB_POWERUP, long_wait: 1'b0};
      4'd1:  x = '{nibble: 4'h3, pause_sel: PB_WAKE2, long_wait: 1'b0};
      4'd2:  x = '{nibble: 4'h3, pause_sel: PB_WAKE3, long_wait: 1'b0};
      4'd3:  x = '{nibble: 4'h2, pause_sel: PB_WAKE3, long_wait: 1'b0};
      4'd4:  x.nibble = 4'h2;
      4'd5:  x.nibble = 4'h8;
      4'd6:  x.nibble = 4'h0;
      4'd7:  x.nibble = 4'hC;
      4'd8:  x.nibble = 4'h0;
      4'd9:  x = '{nibble: 4'h1, pause_sel: PB_NONE, long_wait: 1'b1};
      4'd10: x.nibble = 4'h0;
      4'd11: x.nibble = 4'h6;
      default: x.nibble = 4'h0;
    endcase
    return x;
  endfunction

endpackage

FILE: rtl/lcdns_front.sv
// Front end: accepts requests and classifies them into queued jobs.
module lcdns_front (
  input  logic          start_i,
  input  lcdns_pkg::req_t req_i,
  input  logic          full_i,
  output logic          push_o,
  output lcdns_pkg::job_t job_o
);
  import lcdns_pkg::*;

  logic       known;
  logic [7:0] row_c;
  logic [7:0] col_c;
  logic [7:0] cursor_cmd;

  always_comb begin
    row_c      = (req_i.row > 8'd1) ? 8'd1 : req_i.row;
    col_c      = (req_i.column > MaxColumn) ? MaxColumn : req_i.column;
    cursor_cmd = CmdDdram | (col_c + ((row_c != 8'd0) ? Row1Offset : 8'd0));
  end

  always_comb begin
    known = 1'b1;
    job_o = '{is_init: 1'b0, reg_select: 1'b0, long_wait: 1'b0, byte_value: 8'h00};
    case (req_i.mode)
      MODE_INIT: job_o.is_init = 1'b1;
      MODE_CMD: begin
        job_o.byte_value = req_i.byte_value;
        job_o.long_wait  = (req_i.byte_value == CmdClear) || (req_i.byte_value == CmdHome);
      end
      MODE_DATA: begin
        job_o.byte_value = req_i.byte_value;
        job_o.reg_select = 1'b1;
      end
      MODE_CURSOR: job_o.byte_value = cursor_cmd;
      MODE_CLEAR: begin
        job_o.byte_value = CmdClear;
        job_o.long_wait  = 1'b1;
      end
      default: known = 1'b0;
    endcase
  end

  assign push_o = start_i && !full_i && known;

endmodule

FILE: rtl/lcdns_fifo.sv
// Short job queue between the front end and the transfer sequencer.
module lcdns_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcdns_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            full_o,
  output lcdns_pkg::job_t job_o
);
  import lcdns_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QCntW'(QDepth));
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

FILE: rtl/lcdns_back.sv
// Back end: steps through the transfers of the queued job, one per cycle.
module lcdns_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  lcdns_pkg::job_t job_i,
  input  logic [15:0]     long_wait_us_i,
  input  logic [19:0]     powerup_wait_us_i,
  output logic            pop_o,
  output logic            res_valid_o,
  output lcdns_pkg::res_t res_o
);
  import lcdns_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  logic             valid_q;
  res_t             res_q, res_d;
  init_xfer_t       ix;
  logic             is_last;
  logic             lw;

  always_comb begin
    ix      = init_xfer(step_q);
    is_last = job_i.is_init ? (step_q == StepW'(InitSteps - 1)) : (step_q == StepW'(1));
    pop_o   = valid_i && is_last;
    step_d  = valid_i ? (is_last ? '0 : step_q + 1'b1) : step_q;

    res_d.last = is_last;
    if (job_i.is_init) begin
      res_d.reg_select = 1'b0;
      res_d.nibble     = ix.nibble;
      lw               = ix.long_wait;
      case (ix.pause_sel)
        PB_POWERUP: res_d.pause_before_us = powerup_wait_us_i;
        PB_WAKE2:   res_d.pause_before_us = Wake2Us;
        PB_WAKE3:   res_d.pause_before_us = Wake3Us;
        default:    res_d.pause_before_us = '0;
      endcase
    end else begin
      res_d.reg_select      = job_i.reg_select;
      res_d.nibble          = (step_q == '0) ? job_i.byte_value[7:4] : job_i.byte_value[3:0];
      res_d.pause_before_us = '0;
      lw                    = job_i.long_wait && (step_q != '0);
    end
    res_d.pause_after_us = lw ? long_wait_us_i : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/char_lcd_nibble_sequencer.sv
// Top level of the 4-bit character-LCD nibble sequencer.
// Request channel: an item (req_i) is taken at a rising edge with start_i high
// and busy_o low. Unknown modes are taken and dropped without any transfer.
// Result channel: each nibble transfer is shown on res_o for one cycle with
// res_valid_o high; the receiver cannot stall it. res_o.last marks the final
// transfer of a request.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// always ready. Strobe width and settle time belong to the pin driver and
// are not used here; long wait and power-up wait are read as transfers go out.
// With an empty queue, an accepted request is written into the job queue at
// the accepting edge, and its first transfer is then registered into res_o.
// Throughput: one transfer per clock from the sequencer while a job is queued;
// byte requests give two transfers, init ones 12. A two-entry job queue lets new
// requests be taken while transfers go out; busy_o is the queue being full.
// Reset clears the queue and sequencer and loads the register defaults.
module char_lcd_nibble_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  lcdns_pkg::req_t req_i,
  output logic            res_valid_o,
  output lcdns_pkg::res_t res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [19:0]     cfg_data_i
);
  import lcdns_pkg::*;

  logic [15:0] long_wait_q;
  logic [19:0] powerup_wait_q;
  logic        push;
  job_t        push_job;
  job_t        head_job;
  logic        head_valid;
  logic        full;
  logic        pop;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_wait_q    <= 16'd2000;
      powerup_wait_q <= 20'd40000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LONG:    long_wait_q    <= cfg_data_i[15:0];
        CFG_POWERUP: powerup_wait_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  lcdns_front u_front (
    .start_i(start_i),
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  lcdns_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .valid_o(head_valid),
    .full_o (full),
    .job_o  (head_job)
  );

  lcdns_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (head_valid),
    .job_i            (head_job),
    .long_wait_us_i   (long_wait_q),
    .powerup_wait_us_i(powerup_wait_q),
    .pop_o            (pop),
    .res_valid_o      (res_valid_o),
    .res_o            (res_o)
  );

`ifndef SYNTH
  a_busy_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> head_valid)
    else $error("busy with empty queue");

  a_job_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |=> res_valid_o)
    else $error("queued job produced no transfer");

  a_pop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (res_valid_o && res_o.last))
    else $error("job retired without last transfer");

  a_last_only_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && !pop) |=> !res_o.last)
    else $error("last flagged mid job");
`endif

endmodule
